// ===== design/fid_pkg.sv =====
package fid_pkg;

  // Generator constants of the keystream.
  localparam logic [30:0] LCG_MUL  = 31'h41C6_4E6D;
  localparam logic [13:0] LCG_ADD  = 14'h3039;
  localparam int          GEN_BITS = 15;
  localparam logic [7:0]  SUM_INV  = 8'hFF;

  // Input kinds carried on tuser.
  localparam logic ACT_SEED = 1'b0;
  localparam logic ACT_DATA = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MUL_HI = 6'b000010,
    ST_ADV1   = 6'b000100,
    ST_MUL2   = 6'b001000,
    ST_ADV2   = 6'b010000,
    ST_SPARE  = 6'b100000
  } fid_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_seed;
    logic start;
    logic mul_hi;
    logic adv1;
    logic mul2;
    logic adv2;
  } fid_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic g_hi_zero;
    logic out_busy;
  } fid_stat_t;

endpackage

// ===== design/flash_id_descrambler.sv =====
// Flash ID descrambler. A seed beat (tuser 0) loads the 64-bit keystream
// generator and starts a new ID at position 0; it produces no output.
// Each data beat (tuser 1) advances the generator twice and yields one
// descrambled byte with its position and slot; the final byte of an ID
// (position ID_LENGTH-1) also carries the inverted byte sum and raises
// out_tlast. A data byte takes the block through its accept, MUL_HI (only
// when the upper 32 bits of the generator are nonzero, which only happens
// on the first byte after such a seed), ADV1, MUL2 and ADV2; these steps
// come from the single shared 32 x 31 multiplier, forming two or three
// partial products per byte on the generator feedback path. One finished
// byte can wait in the output register while the next is accepted and
// worked on; a second finished byte is held until the first is taken. The
// generator is not cleared between IDs and runs on until the next seed beat.
module flash_id_descrambler
  import fid_pkg::*;
#(
  parameter int ID_LENGTH = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Fields from bit 0: seed[63:0], data_byte[71:64], slot[72], zero fill.
  input  logic [79:0] in_tdata,
  // Fields from bit 0: action (0 = seed, 1 = data byte).
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // Fields from bit 0: id_byte[7:0], position[11:8], card_slot[12],
  // id_checksum[20:13], zero fill.
  output logic [23:0] out_tdata,
  output logic        out_tlast
);

  fid_cmd_t  cmd;
  fid_stat_t stat;

  logic [7:0] id_byte;
  logic [3:0] position;
  logic       card_slot;
  logic [7:0] id_checksum;

  fid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_action (in_tuser),
    .in_ready  (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fid_dpath #(
    .ID_LENGTH (ID_LENGTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_seed         (in_tdata[63:0]),
    .in_data_byte    (in_tdata[71:64]),
    .in_slot         (in_tdata[72]),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_id_byte     (id_byte),
    .out_position    (position),
    .out_card_slot   (card_slot),
    .out_id_checksum (id_checksum),
    .out_last        (out_tlast)
  );

  assign out_tdata = {3'b0, id_checksum, card_slot, position, id_byte};

endmodule

// ===== design/fid_ctrl.sv =====
module fid_ctrl
  import fid_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_action,
  output logic      in_ready,
  input  fid_stat_t stat,
  output fid_cmd_t  cmd
);

  fid_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_SEED) begin
            cmd.load_seed = 1'b1;
          end else begin
            // The low partial product is formed in the accept cycle.
            cmd.start = 1'b1;
            state_nxt = stat.g_hi_zero ? ST_ADV1 : ST_MUL_HI;
          end
        end
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = ST_ADV1;
      end
      ST_ADV1: begin
        cmd.adv1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_ADV2;
      end
      ST_ADV2: begin
        if (!stat.out_busy) begin
          cmd.adv2  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/fid_dpath.sv =====
module fid_dpath
  import fid_pkg::*;
#(
  parameter int ID_LENGTH = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  fid_cmd_t    cmd,
  output fid_stat_t   stat,
  input  logic [63:0] in_seed,
  input  logic [7:0]  in_data_byte,
  input  logic        in_slot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_id_byte,
  output logic [3:0]  out_position,
  output logic        out_card_slot,
  output logic [7:0]  out_id_checksum,
  output logic        out_last
);

  localparam logic [3:0] LAST_POS = 4'(ID_LENGTH - 1);

  logic [63:0] g_r;
  logic [7:0]  sum_r;
  logic [3:0]  pos_r;
  logic [62:0] lo_r;
  logic [31:0] hi_r;
  logic [7:0]  data_r;
  logic        slot_r;
  logic [7:0]  plain_r;
  logic        out_valid_r;
  logic [7:0]  out_id_byte_r;
  logic [3:0]  out_position_r;
  logic        out_card_slot_r;
  logic [7:0]  out_id_checksum_r;
  logic        out_last_r;

  logic [31:0] mul_a;
  logic [62:0] mul_res;
  logic [63:0] adv1_sum;
  logic [30:0] adv2_sum;
  logic [7:0]  sum_nxt;
  logic        is_last;

  // One shared 32 x 31 multiplier serves every partial product.
  assign mul_a    = cmd.mul_hi ? g_r[63:32] : g_r[31:0];
  assign mul_res  = 63'(mul_a) * 63'(LCG_MUL);
  assign adv1_sum = 64'(lo_r) + {hi_r, 32'b0} + 64'(LCG_ADD);
  assign adv2_sum = lo_r[30:0] + 31'(LCG_ADD);
  assign sum_nxt  = sum_r + plain_r;
  assign is_last  = (pos_r >= LAST_POS);

  assign stat.g_hi_zero = (g_r[63:32] == 32'b0);
  assign stat.out_busy  = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_r         <= '0;
      sum_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !cmd.adv2) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.load_seed) begin
        g_r   <= in_seed;
        sum_r <= '0;
        pos_r <= '0;
      end
      if (cmd.adv1) begin
        g_r <= {16'b0, adv1_sum[63:16]};
      end
      if (cmd.adv2) begin
        g_r         <= 64'(adv2_sum[30:16]);
        out_valid_r <= 1'b1;
        if (is_last) begin
          sum_r <= '0;
          pos_r <= '0;
        end else begin
          sum_r <= sum_nxt;
          pos_r <= pos_r + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      lo_r   <= mul_res;
      hi_r   <= '0;
      data_r <= in_data_byte;
      slot_r <= in_slot;
    end
    if (cmd.mul_hi) begin
      hi_r <= mul_res[31:0];
    end
    if (cmd.adv1) begin
      plain_r <= data_r - adv1_sum[23:16];
    end
    if (cmd.mul2) begin
      lo_r <= mul_res;
    end
    if (cmd.adv2) begin
      out_id_byte_r     <= plain_r;
      out_position_r    <= pos_r;
      out_card_slot_r   <= slot_r;
      out_id_checksum_r <= is_last ? (sum_nxt ^ SUM_INV) : 8'b0;
      out_last_r        <= is_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_id_byte     = out_id_byte_r;
  assign out_position    = out_position_r;
  assign out_card_slot   = out_card_slot_r;
  assign out_id_checksum = out_id_checksum_r;
  assign out_last        = out_last_r;

endmodule
